// ----- hw/rtl/adamax_pkg.sv -----
// ----------------------------------------------------------------------------
// adamax_pkg
// Shared types and constants of the adamax update engine.
// ----------------------------------------------------------------------------
package adamax_pkg;

	localparam int unsigned ElementsDefault = 4096;
	localparam int unsigned IndexW = 12;
	localparam int unsigned DataW = 32;

	localparam logic [15:0] BetaFirstReset = 16'd58982;
	localparam logic [15:0] BetaPeakReset  = 16'd65470;
	localparam logic [23:0] LearnRateReset = 24'd167772;
	localparam logic [23:0] StabilizerReset = 24'd2;

	// configuration register indexes
	localparam logic [1:0] RegBetaFirst = 2'd0;
	localparam logic [1:0] RegBetaPeak  = 2'd1;
	localparam logic [1:0] RegLearnRate = 2'd2;
	localparam logic [1:0] RegStabilizer = 2'd3;

	// one accepted item as it waits for the back end
	typedef struct packed {
		logic [IndexW-1:0] index;
		logic signed [DataW-1:0] grad;
		logic fresh;
		logic [32:0] power;
	} adamax_cmd_t;

endpackage

// ----- hw/rtl/adamax_front.sv -----
// ----------------------------------------------------------------------------
// adamax_front
// Accepts gradient transactions, advances the beta1 power on pass starts
// and pushes commands into a small queue for the back end.
// ----------------------------------------------------------------------------
module adamax_front #(
	parameter int unsigned Depth = 2
) (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     in_valid,
	output logic                     in_ready,
	input  logic [11:0]              in_index,
	input  logic [31:0]              in_grad,
	input  logic                     in_start,
	input  logic                     in_fresh,
	input  logic [15:0]              beta_first,
	output adamax_pkg::adamax_cmd_t  cmd,
	output logic                     cmd_valid,
	input  logic                     cmd_ready
);
	import adamax_pkg::*;

	localparam int unsigned PtrW = (Depth > 1) ? $clog2(Depth) : 1;

	adamax_cmd_t      fifo_q [Depth];
	logic [PtrW-1:0]  wr_q, rd_q;
	logic [PtrW:0]    cnt_q;
	logic [32:0]      power_q;
	logic [32:0]      power_base;
	logic [48:0]      power_prod;
	logic [32:0]      power_next;
	logic             push, pop;

	assign in_ready  = (cnt_q != Depth[PtrW:0]);
	assign cmd_valid = (cnt_q != '0);
	assign cmd       = fifo_q[rd_q];
	assign push      = in_valid && in_ready;
	assign pop       = cmd_valid && cmd_ready;

	// power update for a pass start
	assign power_base = in_fresh ? {1'b1, 32'd0} : power_q;
	assign power_prod = power_base * beta_first + 49'd32768;
	assign power_next = in_start ? power_prod[48:16] : power_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			power_q <= {1'b1, 32'd0};
			wr_q <= '0;
			rd_q <= '0;
			cnt_q <= '0;
		end else begin
			if (push) begin
				power_q <= power_next;
				wr_q <= (wr_q == PtrW'(Depth - 1)) ? '0 : wr_q + 1'b1;
			end
			if (pop) rd_q <= (rd_q == PtrW'(Depth - 1)) ? '0 : rd_q + 1'b1;
			cnt_q <= cnt_q + (PtrW+1)'(push) - (PtrW+1)'(pop);
		end
	end

	// queue storage
	always_ff @(posedge clk) begin
		if (push) begin
			fifo_q[wr_q].index <= in_index;
			fifo_q[wr_q].grad  <= in_grad;
			fifo_q[wr_q].fresh <= in_fresh;
			fifo_q[wr_q].power <= power_next;
		end
	end

endmodule

// ----- hw/rtl/adamax_div.sv -----
// ----------------------------------------------------------------------------
// adamax_div
// Radix-2 restoring divider: round(n * 2^32 / d) with overflow flag.
// ----------------------------------------------------------------------------
module adamax_div (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	input  logic [63:0] numer,
	input  logic [63:0] denom,
	output logic        done,
	output logic [32:0] quot,
	output logic        ovf
);
	import adamax_pkg::*;

	logic [127:0] rem_q;
	logic [63:0]  den_q;
	logic [32:0]  quo_q;
	logic [6:0]   cnt_q;
	logic         busy_q, ovf_q;

	// one quotient bit per cycle over 96 steps; high ones flag overflow
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done <= 1'b0;
			cnt_q <= '0;
			ovf_q <= 1'b0;
		end else begin
			done <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q <= '0;
				ovf_q <= 1'b0;
				rem_q <= {64'd0, numer};
				den_q <= denom;
				quo_q <= '0;
			end else if (busy_q) begin
				// shift remainder, subtract when it fits
				if ({rem_q[127:63]} >= {1'b0, den_q}) begin
					rem_q <= {rem_q[126:63] - den_q, rem_q[62:0], 1'b0};
					if (cnt_q < 7'd64) ovf_q <= 1'b1;
					quo_q <= {quo_q[31:0], 1'b1};
				end else begin
					rem_q <= {rem_q[126:0], 1'b0};
					quo_q <= {quo_q[31:0], 1'b0};
				end
				cnt_q <= cnt_q + 1'b1;
				if (cnt_q == 7'd95) begin
					busy_q <= 1'b0;
					done <= 1'b1;
				end
			end
		end
	end

	// round half up on the final remainder
	assign ovf  = ovf_q;
	assign quot = (rem_q[127:64] >= den_q - rem_q[127:64]) ? quo_q + 1'b1 : quo_q;

endmodule

// ----- hw/rtl/adamax_back.sv -----
// ----------------------------------------------------------------------------
// adamax_back
// Sequencer: reads moments, updates them, divides and holds the result.
// ----------------------------------------------------------------------------
module adamax_back #(
	parameter int unsigned Elements = adamax_pkg::ElementsDefault
) (
	input  logic                    clk,
	input  logic                    arst_n,
	input  adamax_pkg::adamax_cmd_t cmd,
	input  logic                    cmd_valid,
	output logic                    cmd_ready,
	input  logic [15:0]             beta_first,
	input  logic [15:0]             beta_peak,
	input  logic [23:0]             learn_rate,
	input  logic [23:0]             stabilizer,
	output logic                    out_valid,
	input  logic                    out_ready,
	output logic [31:0]             out_delta,
	output logic                    out_sat
);
	import adamax_pkg::*;

	localparam int unsigned AddrW = (Elements > 1) ? $clog2(Elements) : 1;
	localparam logic [2:0] StIdle = 3'd0, StRead = 3'd1, StMom = 3'd2,
		StDen = 3'd3, StDiv = 3'd4, StOut = 3'd5, StMod = 3'd6;
	// index reduction: a mask for power-of-two sizes or sizes of 4096 and up, else a compare-subtract loop
	localparam bit ModLoop = (Elements < (1 << IndexW)) &&
		((Elements & (Elements - 1)) != 0);
	localparam logic [IndexW-1:0] IdxMask = (Elements >= (1 << IndexW)) ?
		{IndexW{1'b1}} : IndexW'(Elements - 1);

	logic [2:0]            state_q;
	adamax_cmd_t           cmd_q;
	logic [AddrW-1:0]      addr_q;
	logic [IndexW-1:0]     red_q;
	logic [3:0]            red_cnt_q;
	logic signed [31:0]    m_mem [Elements];
	logic [31:0]           u_mem [Elements];
	logic signed [31:0]    m_rd_q;
	logic [31:0]           u_rd_q;
	logic signed [31:0]    m_new_q;
	logic [31:0]           u_new_q;
	logic [63:0]           numer_q, denom_q;
	logic                  div_start_q, div_done, div_ovf;
	logic [32:0]           div_quot;
	logic [31:0]           delta_q;
	logic                  sat_q, valid_q;

	logic signed [31:0]    m_old, g;
	logic [31:0]           u_old;
	logic signed [49:0]    m_sum;
	logic [49:0]           m_mag;
	logic [49:0]           m_rnd;
	logic [47:0]           u_prod;
	logic [31:0]           u_dec, g_abs;
	logic [31:0]           m_abs;
	logic [32:0]           bias;
	logic [32:0]           u_eps;
	logic [32:0]           limit, q_fin;
	logic                  s_fin;
	logic [31:0]           mod_sub;
	logic [IndexW-1:0]     red_next;

	assign cmd_ready = (state_q == StIdle);
	assign out_valid = valid_q;
	assign out_delta = delta_q;
	assign out_sat   = sat_q;

	// one compare-subtract step of the index reduction
	assign mod_sub  = 32'(Elements) << red_cnt_q;
	assign red_next = (32'(red_q) >= mod_sub) ? red_q - mod_sub[IndexW-1:0] : red_q;

	// moment arithmetic from the registered read data
	assign g      = cmd_q.grad;
	assign m_old  = cmd_q.fresh ? 32'sd0 : m_rd_q;
	assign u_old  = cmd_q.fresh ? 32'd0 : u_rd_q;
	assign m_sum  = $signed({1'b0, beta_first}) * m_old
		+ $signed({1'b0, 17'd65536 - {1'b0, beta_first}}) * g;
	assign m_mag  = m_sum[49] ? 50'(-m_sum) : 50'(m_sum);
	assign m_rnd  = (m_mag + 50'd32768) >> 16;
	assign u_prod = beta_peak * u_old + 48'd32768;
	assign u_dec  = u_prod[47:16];
	assign g_abs  = g[31] ? 32'(-g) : 32'(g);

	assign m_abs  = m_new_q[31] ? 32'(-m_new_q) : 32'(m_new_q);
	assign bias   = {1'b1, 32'd0} - cmd_q.power;
	assign u_eps  = {1'b0, u_new_q} + {9'd0, stabilizer};
	assign limit  = (m_new_q > 0) ? {2'b01, 31'd0} : {2'b00, 31'h7FFF_FFFF};

	// final clip
	always_comb begin
		q_fin = '0;
		s_fin = 1'b0;
		if (numer_q == 64'd0) begin
			q_fin = '0;
		end else if (denom_q == 64'd0 || div_ovf || div_quot > limit) begin
			q_fin = limit;
			s_fin = 1'b1;
		end else begin
			q_fin = div_quot;
		end
	end

	adamax_div u_div (
		.clk(clk), .arst_n(arst_n), .start(div_start_q),
		.numer(numer_q), .denom(denom_q),
		.done(div_done), .quot(div_quot), .ovf(div_ovf)
	);

	// memory ports
	always_ff @(posedge clk) begin
		if (state_q == StRead) begin
			m_rd_q <= m_mem[addr_q];
			u_rd_q <= u_mem[addr_q];
		end
		if (state_q == StDen) begin
			m_mem[addr_q] <= m_new_q;
			u_mem[addr_q] <= u_new_q;
		end
	end

	// sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= StIdle;
			valid_q <= 1'b0;
			div_start_q <= 1'b0;
		end else begin
			div_start_q <= (state_q == StDen);
			if (state_q == StOut && (!valid_q || out_ready)) valid_q <= 1'b1;
			else if (out_ready) valid_q <= 1'b0;
			case (state_q)
				StIdle: begin
					if (cmd_valid) begin
						cmd_q <= cmd;
						addr_q <= AddrW'(cmd.index & IdxMask);
						red_q <= cmd.index;
						red_cnt_q <= 4'(IndexW - 1);
						state_q <= ModLoop ? StMod : StRead;
					end
				end
				StMod: begin
					red_q <= red_next;
					red_cnt_q <= red_cnt_q - 1'b1;
					if (red_cnt_q == 4'd0) begin
						addr_q <= AddrW'(red_next);
						state_q <= StRead;
					end
				end
				StRead: state_q <= StMom;
				StMom: begin
					m_new_q <= m_sum[49] ? 32'(-m_rnd) : 32'(m_rnd);
					u_new_q <= (u_dec > g_abs) ? u_dec : g_abs;
					state_q <= StDen;
				end
				StDen: begin
					numer_q <= {40'd0, learn_rate} * {32'd0, m_abs};
					denom_q <= {31'd0, bias} * {31'd0, u_eps};
					state_q <= StDiv;
				end
				StDiv: if (div_done) state_q <= StOut;
				StOut: begin
					if (!valid_q || out_ready) begin
						delta_q <= (m_new_q > 0) ? 32'(-q_fin) : q_fin[31:0];
						sat_q <= s_fin;
						state_q <= StIdle;
					end
				end
				default: state_q <= StIdle;
			endcase
		end
	end

endmodule

// ----- hw/rtl/adamax_update_engine.sv -----
// ----------------------------------------------------------------------------
// adamax_update_engine
// Adamax optimizer update over stored per-element moments.
// ----------------------------------------------------------------------------
// Usage: s_axis carries one gradient element per transaction; m_axis returns
// one delta per element in the same order. cfg writes the four registers by
// index and is to be written only while the engine is idle; the engine itself
// does not enforce this. Each element passes through the back end in order:
// taking the command, a memory read, a moment update, one multiply stage for
// numerator and divisor, a divider load, 96 divider steps of one bit each,
// seeing the divider finish and loading the output register. A table size
// below 4096 that is not a power of two adds an index reduction loop before
// the memory read.
// A two-entry command queue lets the front end accept the next element
// while the back end works or while a result waits in the output register.
// Reset clears the queue, the beta1 power (to one) and the registers to
// their defaults; the moment memories are undefined until written.
// When m_axis_tready stays low the result holds and, once the queue fills,
// s_axis_tready drops.
// ----------------------------------------------------------------------------
module adamax_update_engine #(
	parameter int unsigned Elements = adamax_pkg::ElementsDefault
) (
	input  logic        clk,
	input  logic        arst_n,
	// tdata: element_index[11:0], gradient[43:12], zero fill
	input  logic [47:0] s_axis_tdata,
	// tuser: pass_start[0], fresh[1]
	input  logic [1:0]  s_axis_tuser,
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	// tdata: delta[31:0]
	output logic [31:0] m_axis_tdata,
	// tuser: saturated[0]
	output logic        m_axis_tuser,
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [1:0]  cfg_index,
	input  logic [23:0] cfg_data
);
	import adamax_pkg::*;

	logic [15:0] beta_first_q, beta_peak_q;
	logic [23:0] learn_rate_q, stabilizer_q;
	adamax_cmd_t cmd;
	logic        cmd_valid, cmd_ready;

	assign cfg_ready = 1'b1;

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			beta_first_q <= BetaFirstReset;
			beta_peak_q <= BetaPeakReset;
			learn_rate_q <= LearnRateReset;
			stabilizer_q <= StabilizerReset;
		end else if (cfg_valid) begin
			case (cfg_index)
				RegBetaFirst: beta_first_q <= cfg_data[15:0];
				RegBetaPeak: beta_peak_q <= cfg_data[15:0];
				RegLearnRate: learn_rate_q <= cfg_data;
				RegStabilizer: stabilizer_q <= cfg_data;
				default: ;
			endcase
		end
	end

	adamax_front #(.Depth(2)) u_front (
		.clk(clk), .arst_n(arst_n),
		.in_valid(s_axis_tvalid), .in_ready(s_axis_tready),
		.in_index(s_axis_tdata[11:0]), .in_grad(s_axis_tdata[43:12]),
		.in_start(s_axis_tuser[0]), .in_fresh(s_axis_tuser[1]),
		.beta_first(beta_first_q),
		.cmd(cmd), .cmd_valid(cmd_valid), .cmd_ready(cmd_ready)
	);

	adamax_back #(.Elements(Elements)) u_back (
		.clk(clk), .arst_n(arst_n),
		.cmd(cmd), .cmd_valid(cmd_valid), .cmd_ready(cmd_ready),
		.beta_first(beta_first_q), .beta_peak(beta_peak_q),
		.learn_rate(learn_rate_q), .stabilizer(stabilizer_q),
		.out_valid(m_axis_tvalid), .out_ready(m_axis_tready),
		.out_delta(m_axis_tdata), .out_sat(m_axis_tuser)
	);

`ifndef SYNTHESIS
	// a held result does not change
	assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && !m_axis_tready |=> $stable(m_axis_tdata))
		else $error("result changed while stalled");
	// a saturated delta is at an extreme
	assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && m_axis_tuser |->
		(m_axis_tdata == 32'h8000_0000 || m_axis_tdata == 32'h7FFF_FFFF))
		else $error("saturated delta not at a limit");
`endif

endmodule

// ----- bench/tb_top.sv -----
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the adamax update engine: a scoreboard class
// tracks the moment memories, the beta1 power and the registers, and
// predicts each delta and its saturation flag from the accepted gradients.
// Directed corners run first, then random passes under several register
// settings. Both stream sides idle in random bursts, and the output side
// stalls for a long stretch once.
// ----------------------------------------------------------------------------
module tb_top;
	import adamax_pkg::*;

	localparam int unsigned CycleLimit = 2000000;
	localparam int unsigned DrainCycles = 150;

	typedef struct {
		logic [31:0] delta;
		logic        sat;
	} delta_t;

	class adamax_scoreboard;
		logic [15:0] b1, b2;
		logic [23:0] eta, eps;
		int first_mom [ElementsDefault];
		int unsigned peak_mom [ElementsDefault];
		longint unsigned power;
		delta_t expected_deltas [$];
		int errors;

		function new();
			b1 = BetaFirstReset;
			b2 = BetaPeakReset;
			eta = LearnRateReset;
			eps = StabilizerReset;
			power = 64'h1_0000_0000;
			errors = 0;
		endfunction

		function void write_reg(logic [1:0] idx, logic [23:0] v);
			case (idx)
				RegBetaFirst:  b1 = v[15:0];
				RegBetaPeak:   b2 = v[15:0];
				RegLearnRate:  eta = v;
				RegStabilizer: eps = v;
				default: ;
			endcase
		endfunction

		// divide by 2^16, nearest, ties away from zero
		function longint round16(longint x);
			longint unsigned mag;
			mag = (x < 0) ? -x : x;
			mag = (mag + 32768) >> 16;
			return (x < 0) ? -longint'(mag) : longint'(mag);
		endfunction

		// predict the delta for one accepted gradient
		function void note_item(logic [11:0] idx, logic signed [31:0] g, bit start, bit fresh);
			longint m_old, m_new, gl;
			longint unsigned u_old, u_dec, g_abs, u_new, bias, denom, numer, mag, lim;
			logic [127:0] wide, qq, rr;
			delta_t e;
			if (start) begin
				if (fresh)
					power = 64'h1_0000_0000;
				power = (power * longint'(b1) + 32768) >> 16;
			end
			gl = g;
			m_old = fresh ? 0 : first_mom[idx];
			u_old = fresh ? 0 : peak_mom[idx];
			m_new = round16(longint'(b1) * m_old + (65536 - longint'(b1)) * gl);
			u_dec = (longint'(b2) * u_old + 32768) >> 16;
			g_abs = (gl < 0) ? -gl : gl;
			u_new = (u_dec > g_abs) ? u_dec : g_abs;
			first_mom[idx] = int'(m_new);
			peak_mom[idx] = u_new[31:0];
			bias = 64'h1_0000_0000 - power;
			denom = bias * (u_new + longint'(eps));
			mag = (m_new < 0) ? -m_new : m_new;
			numer = longint'(eta) * mag;
			lim = (m_new > 0) ? 64'h8000_0000 : 64'h7FFF_FFFF;
			e.sat = 1'b0;
			if (numer == 0) begin
				qq = '0;
			end else if (denom == 0) begin
				qq = lim;
				e.sat = 1'b1;
			end else begin
				wide = {32'b0, numer, 32'b0};
				qq = wide / denom;
				rr = wide % denom;
				if (rr >= denom - rr)
					qq = qq + 1;
				if (qq > lim) begin
					qq = lim;
					e.sat = 1'b1;
				end
			end
			e.delta = (m_new > 0) ? -qq[31:0] : qq[31:0];
			expected_deltas.push_back(e);
		endfunction

		function void check(logic [31:0] d, logic s);
			delta_t e;
			if (expected_deltas.size() == 0) begin
				$error("unexpected delta transaction %h", d);
				errors++;
				return;
			end
			e = expected_deltas.pop_front();
			if (d !== e.delta) begin
				$error("delta expected %h actual %h", e.delta, d);
				errors++;
			end
			if (s !== e.sat) begin
				$error("saturated expected %0b actual %0b", e.sat, s);
				errors++;
			end
		endfunction
	endclass

	logic        clk;
	logic        arst_n;
	logic [47:0] s_axis_tdata;
	logic [1:0]  s_axis_tuser;
	logic        s_axis_tvalid;
	logic        s_axis_tready;
	logic [31:0] m_axis_tdata;
	logic        m_axis_tuser;
	logic        m_axis_tvalid;
	logic        m_axis_tready;
	logic        cfg_valid;
	logic        cfg_ready;
	logic [1:0]  cfg_index;
	logic [23:0] cfg_data;

	adamax_scoreboard sb = new();
	bit written [ElementsDefault];
	bit idling;
	bit hold_req;
	int unsigned cycles;

	adamax_update_engine DUT (
		.clk(clk), .arst_n(arst_n),
		.s_axis_tdata(s_axis_tdata), .s_axis_tuser(s_axis_tuser),
		.s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
		.m_axis_tdata(m_axis_tdata), .m_axis_tuser(m_axis_tuser),
		.m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
		.cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
		.cfg_index(cfg_index), .cfg_data(cfg_data)
	);

	always begin
		clk = 1'b1;
		#1;
		clk = 1'b0;
		#1;
	end

	// run limit
	always @(posedge clk) begin
		cycles++;
		if (cycles > CycleLimit) begin
			$display("SCOREBOARD MISMATCH");
			$finish;
		end
	end

	// result transactions
	always @(posedge clk) begin
		if (arst_n && m_axis_tvalid && m_axis_tready)
			sb.check(m_axis_tdata, m_axis_tuser);
	end

	// output side readiness, bursts of stall and one long hold-off
	initial begin
		m_axis_tready = 1'b0;
		forever begin
			@(negedge clk);
			if (hold_req) begin
				m_axis_tready = 1'b0;
				repeat (700) @(negedge clk);
				hold_req = 1'b0;
			end else if (idling && $urandom_range(0, 3) == 0) begin
				m_axis_tready = 1'b0;
				repeat ($urandom_range(1, 18)) @(negedge clk);
			end
			m_axis_tready = 1'b1;
		end
	end

	task automatic send_item(logic [11:0] idx, logic [31:0] g, bit start, bit fresh);
		if (!written[idx])
			fresh = 1'b1;
		if (idling && $urandom_range(0, 4) == 0)
			repeat ($urandom_range(1, 18)) @(negedge clk);
		s_axis_tdata = {4'b0, g, idx};
		s_axis_tuser = {fresh, start};
		s_axis_tvalid = 1'b1;
		do
			@(posedge clk);
		while (!s_axis_tready);
		sb.note_item(idx, g, start, fresh);
		written[idx] = 1'b1;
		@(negedge clk);
		s_axis_tvalid = 1'b0;
	endtask

	task automatic write_cfg(logic [1:0] idx, logic [23:0] v);
		cfg_index = idx;
		cfg_data = v;
		cfg_valid = 1'b1;
		do
			@(posedge clk);
		while (!cfg_ready);
		sb.write_reg(idx, v);
		@(negedge clk);
		cfg_valid = 1'b0;
	endtask

	// wait until every delta is back, then write all four registers
	task automatic set_regs(logic [15:0] b1, logic [15:0] b2, logic [23:0] eta,
			logic [23:0] eps);
		while (sb.expected_deltas.size() != 0)
			@(negedge clk);
		repeat (4) @(negedge clk);
		write_cfg(RegBetaFirst, {8'b0, b1});
		write_cfg(RegBetaPeak, {8'b0, b2});
		write_cfg(RegLearnRate, eta);
		write_cfg(RegStabilizer, eps);
	endtask

	task automatic random_item();
		logic [11:0] idx;
		logic [31:0] g;
		case ($urandom_range(0, 9))
			0: idx = 12'($urandom_range(0, 4095));
			default: idx = 12'($urandom_range(0, 23));
		endcase
		case ($urandom_range(0, 7))
			0: g = $urandom();
			1: g = $urandom_range(0, 1) ? 32'h7FFF_FFFF : 32'h8000_0000;
			2: g = 32'($signed($urandom_range(0, 255)) - 128);
			default: g = 32'($signed($urandom_range(0, 32'h0200_0000)) - 32'sh0100_0000);
		endcase
		send_item(idx, g, $urandom_range(0, 7) == 0, $urandom_range(0, 11) == 0);
	endtask

	initial begin
		logic [23:0] phase_regs [6][4];
		phase_regs = '{
			'{24'd58982, 24'd65470, 24'd167772, 24'd2},
			'{24'd1, 24'd1, 24'hFF_FFFF, 24'd1},
			'{24'd65535, 24'd65535, 24'd1, 24'hFF_FFFF},
			'{24'd0, 24'd0, 24'd0, 24'd0},
			'{24'd32768, 24'd60000, 24'hFF_FFFF, 24'd0},
			'{24'd58982, 24'd65470, 24'd4000000, 24'd100}
		};
		arst_n = 1'b0;
		s_axis_tdata = '0;
		s_axis_tuser = '0;
		s_axis_tvalid = 1'b0;
		cfg_valid = 1'b0;
		cfg_index = RegBetaFirst;
		cfg_data = '0;
		idling = 1'b0;
		hold_req = 1'b0;
		repeat (10) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// no pass start yet: zero bias saturates any nonzero numerator
		send_item(12'd0, 32'h7FFF_FFFF, 0, 1);
		send_item(12'd1, 32'h8000_0000, 0, 1);
		send_item(12'd2, 32'h0000_0000, 0, 1);
		// first pass with extremes of the fields
		send_item(12'd4095, 32'h8000_0000, 1, 1);
		send_item(12'd0, 32'h7FFF_FFFF, 0, 0);
		send_item(12'd1, 32'h0000_0001, 0, 0);
		send_item(12'd2, 32'hFFFF_FFFF, 0, 0);
		send_item(12'd2730, 32'h5555_5555, 0, 1);
		send_item(12'd1365, 32'hAAAA_AAAA, 0, 1);
		send_item(12'd3, 32'h0000_0000, 0, 1);
		// further passes, one restarted by fresh
		send_item(12'd0, 32'h0100_0000, 1, 0);
		send_item(12'd4095, 32'hFF00_0000, 0, 0);
		send_item(12'd0, 32'h0000_0010, 1, 0);
		send_item(12'd1, 32'hFFFF_FFF0, 1, 1);
		send_item(12'd1, 32'h0000_0000, 0, 0);

		idling = 1'b1;
		for (int ph = 0; ph < 6; ph++) begin
			set_regs(phase_regs[ph][0][15:0], phase_regs[ph][1][15:0],
				phase_regs[ph][2], phase_regs[ph][3]);
			if (ph == 5)
				idling = 1'b0;
			if (ph == 1)
				hold_req = 1'b1;
			send_item(12'd0, $urandom(), 1, 0);
			for (int i = 0; i < 90; i++)
				random_item();
		end

		while (sb.expected_deltas.size() != 0)
			@(negedge clk);
		repeat (DrainCycles) @(posedge clk);
		if (sb.errors == 0)
			$display("SCOREBOARD CLEAN");
		else
			$display("SCOREBOARD MISMATCH");
		$finish;
	end

endmodule
